// ===== design/tts_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants of the thread table scheduler.
// Used by tts_table, thread_table_scheduler and tts_checker; depends on nothing.
package tts_pkg;

	localparam int THREADS = 128;
	localparam int SLOT_W  = $clog2(THREADS);
	localparam int CNT_W   = $clog2(THREADS + 1);

	// Fixed field widths of the stream beats.
	localparam int CMD_W    = 3;
	localparam int TARGET_W = 7;
	localparam int RUN_W    = 7;
	localparam int NEWID_W  = 7;
	localparam int STATUS_W = 2;
	localparam int IN_W     = 16;
	localparam int OUT_W    = 16;

	typedef enum logic [1:0] {
		ST_INVALID  = 2'd0,
		ST_ACTIVE   = 2'd1,
		ST_BLOCKED  = 2'd2,
		ST_FINISHED = 2'd3
	} slot_st_t;

	typedef enum logic [CMD_W-1:0] {
		CMD_CREATE = 3'd0,
		CMD_YIELD  = 3'd1,
		CMD_EXIT   = 3'd2,
		CMD_JOIN   = 3'd3,
		CMD_TICK   = 3'd4
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STS_OK      = 2'd0,
		STS_NOFREE  = 2'd1,
		STS_NOOTHER = 2'd2,
		STS_BADJOIN = 2'd3
	} status_t;

	typedef struct packed {
		slot_st_t          st;
		logic              jv;
		logic [SLOT_W-1:0] js;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic              en;
		logic [SLOT_W-1:0] addr;
		entry_t            ent;
	} wr_req_t;

	// Next slot in ring order.
	function automatic logic [SLOT_W-1:0] slot_inc(input logic [SLOT_W-1:0] s);
		logic [SLOT_W-1:0] r;
		if (s == SLOT_W'(THREADS - 1)) begin
			r = '0;
		end else begin
			r = s + 1'b1;
		end
		return r;
	endfunction

	// Contents of an entry that has not been written since reset.
	function automatic entry_t reset_entry(input logic [SLOT_W-1:0] a);
		entry_t e;
		e.st = (a == '0) ? ST_ACTIVE : ST_INVALID;
		e.jv = 1'b0;
		e.js = '0;
		return e;
	endfunction

endpackage

// ===== design/thread_table_scheduler.sv =====
`timescale 1ns / 1ps
// Top level of the thread table scheduler: command sequencer around the slot table.
// Depends on tts_pkg and tts_table.
//
//  Channel  | Handshake               | Payload
//  ---------+-------------------------+---------------------------------------
//  command  | s_tvalid / s_tready     | s_tdata: cmd, target
//  result   | m_tvalid / m_tready     | m_tdata: running, new_id, status
//  config   | psel/penable/pwrite     | paddr, pwdata, prdata (preempt_enable)
//
// One command is worked at a time, with one table read and at most one write per cycle.
// Create, yield, a preempting tick and exit without a joiner scan the table for a slot;
// exit with a joiner wakes the joiner instead; join is rejected at once, answered after a
// read of an invalid or finished target, or blocks the caller; other commands answer at once.
// A new command beat is taken only once the previous result beat has been taken.
// After reset the table reads as slot 0 active, all others invalid, with no clearing pass.
module thread_table_scheduler (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [tts_pkg::IN_W-1:0]     s_tdata,  // [2:0] cmd, [9:3] target
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [tts_pkg::OUT_W-1:0]    m_tdata,  // [6:0] running, [13:7] new_id, [15:14] status
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [2:0]                   paddr,
	input  logic [31:0]                  pwdata,
	output logic [31:0]                  prdata,
	output logic                         pready
);

	typedef enum logic [3:0] {
		IDLE, SCAN, EXIT_RD, EXIT_CHK, WAKE_RD, WAKE_WR, JOIN_RD, JOIN_CHK, BLK_RD, BLK_WR
	} fsm_t;

	fsm_t                             state_q;
	logic [tts_pkg::TARGET_W-1:0]     target_q;
	logic [tts_pkg::SLOT_W-1:0]       cur_q;
	logic [tts_pkg::SLOT_W-1:0]       sec_q;
	logic [tts_pkg::SLOT_W-1:0]       scan_addr_q;
	logic [tts_pkg::SLOT_W-1:0]       chk_addr_q;
	logic [tts_pkg::CNT_W-1:0]        cnt_q;
	logic                             pend_q;
	logic                             create_q;
	logic                             preempt_q;
	logic                             m_tvalid_q;
	logic [tts_pkg::RUN_W-1:0]        running_q;
	logic [tts_pkg::NEWID_W-1:0]      new_id_q;
	tts_pkg::status_t                 status_q;

	tts_pkg::rd_req_t                 rd;
	tts_pkg::wr_req_t                 wr;
	tts_pkg::entry_t                  ent;

	logic                             in_acc;
	tts_pkg::cmd_t                    in_cmd;
	logic [tts_pkg::TARGET_W-1:0]     in_target;
	logic [tts_pkg::SLOT_W-1:0]       tgt_slot;
	logic                             scan_hit;
	logic                             cfg_wr;

	assign in_cmd    = tts_pkg::cmd_t'(s_tdata[tts_pkg::CMD_W-1:0]);
	assign in_target = s_tdata[tts_pkg::CMD_W +: tts_pkg::TARGET_W];
	assign s_tready  = (state_q == IDLE) && !m_tvalid_q;
	assign in_acc    = s_tvalid && s_tready;
	assign tgt_slot  = tts_pkg::SLOT_W'(target_q);
	assign scan_hit  = pend_q &&
		(ent.st == (create_q ? tts_pkg::ST_INVALID : tts_pkg::ST_ACTIVE));

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {status_q, new_id_q, running_q};

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = {31'd0, preempt_q && (paddr[2] == 1'b0)};

	tts_table u_table (
		.clk    (clk),
		.arst_n (arst_n),
		.rd     (rd),
		.wr     (wr),
		.rd_ent (ent)
	);

	// Table port requests follow the sequencer state.
	always_comb begin
		rd = '0;
		wr = '0;
		unique case (state_q)
			SCAN: begin
				rd.en   = (cnt_q != '0);
				rd.addr = scan_addr_q;
				if (scan_hit && create_q) begin
					wr.en     = 1'b1;
					wr.addr   = chk_addr_q;
					wr.ent.st = tts_pkg::ST_ACTIVE;
				end
			end
			EXIT_RD, BLK_RD: begin
				rd.en   = 1'b1;
				rd.addr = cur_q;
			end
			EXIT_CHK: begin
				wr.en   = 1'b1;
				wr.addr = cur_q;
				if (ent.jv) begin
					wr.ent.st = tts_pkg::ST_INVALID;
				end else begin
					wr.ent    = ent;
					wr.ent.st = tts_pkg::ST_FINISHED;
				end
			end
			WAKE_RD: begin
				rd.en   = 1'b1;
				rd.addr = sec_q;
			end
			WAKE_WR: begin
				wr.en     = 1'b1;
				wr.addr   = sec_q;
				wr.ent    = ent;
				wr.ent.st = tts_pkg::ST_ACTIVE;
			end
			JOIN_RD: begin
				rd.en   = 1'b1;
				rd.addr = tgt_slot;
			end
			JOIN_CHK: begin
				wr.addr = tgt_slot;
				if (ent.st == tts_pkg::ST_FINISHED) begin
					wr.en     = 1'b1;
					wr.ent.st = tts_pkg::ST_INVALID;
				end else if (ent.st != tts_pkg::ST_INVALID) begin
					wr.en     = 1'b1;
					wr.ent.st = tts_pkg::ST_ACTIVE;
					wr.ent.jv = 1'b1;
					wr.ent.js = cur_q;
				end
			end
			BLK_WR: begin
				wr.en     = 1'b1;
				wr.addr   = cur_q;
				wr.ent    = ent;
				wr.ent.st = tts_pkg::ST_BLOCKED;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			target_q    <= '0;
			cur_q       <= '0;
			sec_q       <= '0;
			scan_addr_q <= '0;
			chk_addr_q  <= '0;
			cnt_q       <= '0;
			pend_q      <= 1'b0;
			create_q    <= 1'b0;
			preempt_q   <= 1'b0;
			m_tvalid_q  <= 1'b0;
			running_q   <= '0;
			new_id_q    <= '0;
			status_q    <= tts_pkg::STS_OK;
		end else begin
			if (cfg_wr && (paddr[2] == 1'b0)) begin
				preempt_q <= pwdata[0];
			end
			if (m_tvalid_q && m_tready) begin
				m_tvalid_q <= 1'b0;
			end

			unique case (state_q)
				IDLE: begin
					if (in_acc) begin
						target_q <= in_target;
						new_id_q <= '0;
						pend_q   <= 1'b0;
						unique case (in_cmd)
							tts_pkg::CMD_CREATE: begin
								create_q    <= 1'b1;
								scan_addr_q <= '0;
								cnt_q       <= tts_pkg::CNT_W'(tts_pkg::THREADS);
								state_q     <= SCAN;
							end
							tts_pkg::CMD_YIELD: begin
								create_q    <= 1'b0;
								scan_addr_q <= tts_pkg::slot_inc(cur_q);
								cnt_q       <= tts_pkg::CNT_W'(tts_pkg::THREADS - 1);
								state_q     <= SCAN;
							end
							tts_pkg::CMD_TICK: begin
								if (preempt_q) begin
									create_q    <= 1'b0;
									scan_addr_q <= tts_pkg::slot_inc(cur_q);
									cnt_q       <= tts_pkg::CNT_W'(tts_pkg::THREADS - 1);
									state_q     <= SCAN;
								end else begin
									m_tvalid_q <= 1'b1;
									running_q  <= tts_pkg::RUN_W'(cur_q);
									status_q   <= tts_pkg::STS_OK;
								end
							end
							tts_pkg::CMD_EXIT: begin
								state_q <= EXIT_RD;
							end
							tts_pkg::CMD_JOIN: begin
								// Out-of-range targets and a join on oneself are rejected
								// without touching the table.
								if (({1'b0, in_target} >= (tts_pkg::TARGET_W + 1)'(tts_pkg::THREADS))
										|| (tts_pkg::SLOT_W'(in_target) == cur_q)) begin
									m_tvalid_q <= 1'b1;
									running_q  <= tts_pkg::RUN_W'(cur_q);
									status_q   <= tts_pkg::STS_BADJOIN;
								end else begin
									state_q <= JOIN_RD;
								end
							end
							default: begin
								m_tvalid_q <= 1'b1;
								running_q  <= tts_pkg::RUN_W'(cur_q);
								status_q   <= tts_pkg::STS_OK;
							end
						endcase
					end
				end
				SCAN: begin
					// Reads are issued back to back; each entry is checked in the cycle after its read.
					if (cnt_q != '0) begin
						scan_addr_q <= tts_pkg::slot_inc(scan_addr_q);
						chk_addr_q  <= scan_addr_q;
						cnt_q       <= cnt_q - 1'b1;
					end
					pend_q <= (cnt_q != '0);
					if (scan_hit) begin
						m_tvalid_q <= 1'b1;
						status_q   <= tts_pkg::STS_OK;
						state_q    <= IDLE;
						if (create_q) begin
							new_id_q  <= tts_pkg::NEWID_W'(chk_addr_q);
							running_q <= tts_pkg::RUN_W'(cur_q);
						end else begin
							cur_q     <= chk_addr_q;
							running_q <= tts_pkg::RUN_W'(chk_addr_q);
						end
					end else if (!pend_q && (cnt_q == '0)) begin
						m_tvalid_q <= 1'b1;
						running_q  <= tts_pkg::RUN_W'(cur_q);
						status_q   <= create_q ? tts_pkg::STS_NOFREE : tts_pkg::STS_NOOTHER;
						state_q    <= IDLE;
					end
				end
				EXIT_RD: begin
					state_q <= EXIT_CHK;
				end
				EXIT_CHK: begin
					if (ent.jv) begin
						sec_q   <= ent.js;
						state_q <= WAKE_RD;
					end else begin
						create_q    <= 1'b0;
						pend_q      <= 1'b0;
						scan_addr_q <= tts_pkg::slot_inc(cur_q);
						cnt_q       <= tts_pkg::CNT_W'(tts_pkg::THREADS - 1);
						state_q     <= SCAN;
					end
				end
				WAKE_RD: begin
					state_q <= WAKE_WR;
				end
				WAKE_WR: begin
					cur_q      <= sec_q;
					m_tvalid_q <= 1'b1;
					running_q  <= tts_pkg::RUN_W'(sec_q);
					status_q   <= tts_pkg::STS_OK;
					state_q    <= IDLE;
				end
				JOIN_RD: begin
					state_q <= JOIN_CHK;
				end
				JOIN_CHK: begin
					if ((ent.st == tts_pkg::ST_INVALID) || (ent.st == tts_pkg::ST_FINISHED)) begin
						m_tvalid_q <= 1'b1;
						running_q  <= tts_pkg::RUN_W'(cur_q);
						status_q   <= (ent.st == tts_pkg::ST_INVALID) ?
							tts_pkg::STS_BADJOIN : tts_pkg::STS_OK;
						state_q    <= IDLE;
					end else begin
						state_q <= BLK_RD;
					end
				end
				BLK_RD: begin
					state_q <= BLK_WR;
				end
				BLK_WR: begin
					cur_q      <= tgt_slot;
					m_tvalid_q <= 1'b1;
					running_q  <= tts_pkg::RUN_W'(tgt_slot);
					status_q   <= tts_pkg::STS_OK;
					state_q    <= IDLE;
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/tts_table.sv =====
`timescale 1ns / 1ps
// Slot table: one synchronous memory of slot entries with a registered read.
// Per-entry valid bits make unwritten entries read as their reset contents.
// Depends on tts_pkg.
module tts_table (
	input  logic             clk,
	input  logic             arst_n,
	input  tts_pkg::rd_req_t rd,
	input  tts_pkg::wr_req_t wr,
	output tts_pkg::entry_t  rd_ent
);

	tts_pkg::entry_t               mem [tts_pkg::THREADS];
	logic [tts_pkg::THREADS-1:0]   vld_q;
	tts_pkg::entry_t               rd_data_s1;
	logic                          rd_vld_s1;
	logic [tts_pkg::SLOT_W-1:0]    rd_addr_s1;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.addr] <= wr.ent;
		end
		if (rd.en) begin
			rd_data_s1 <= mem[rd.addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q      <= '0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
		end else begin
			if (wr.en) begin
				vld_q[wr.addr] <= 1'b1;
			end
			if (rd.en) begin
				rd_vld_s1  <= vld_q[rd.addr];
				rd_addr_s1 <= rd.addr;
			end
		end
	end

	assign rd_ent = rd_vld_s1 ? rd_data_s1 : tts_pkg::reset_entry(rd_addr_s1);

endmodule

// ===== design/tts_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the thread table scheduler, bound to the top level.
// Depends on tts_pkg and thread_table_scheduler.
module tts_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      s_tvalid,
	input logic                      s_tready,
	input logic [tts_pkg::IN_W-1:0]  s_tdata,
	input logic                      m_tvalid,
	input logic                      m_tready,
	input logic [tts_pkg::OUT_W-1:0] m_tdata
);

	localparam int NEWID_LO  = tts_pkg::RUN_W;
	localparam int STATUS_LO = tts_pkg::RUN_W + tts_pkg::NEWID_W;

	// A stalled result beat holds its value.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// A command is taken only when no result is pending.
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |-> !m_tvalid)
		else $error("command taken while a result is pending");

	// Commands are worked one at a time.
	a_no_b2b: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("command taken in consecutive cycles");

	// A nonzero claimed slot only comes with an ok status.
	a_newid_ok: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[NEWID_LO +: tts_pkg::NEWID_W] != '0) |->
		m_tdata[STATUS_LO +: tts_pkg::STATUS_W] == tts_pkg::STS_OK)
		else $error("claimed slot reported with a failing status");

endmodule

bind thread_table_scheduler tts_checker u_tts_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tdata  (s_tdata),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== test/tts_checker.sv =====
`timescale 1ns / 1ps
// Scoreboard for the thread table scheduler: predicts each result beat from the command beats.
// Watches the command, result and APB channels; depends on tts_pkg.
module tts_scoreboard (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	input  logic                               s_tready,
	input  logic [tts_pkg::IN_W-1:0]           s_tdata,  // [2:0] cmd, [9:3] target
	input  logic                               m_tvalid,
	input  logic                               m_tready,
	input  logic [tts_pkg::OUT_W-1:0]          m_tdata,  // [6:0] running, [13:7] new_id, [15:14] status
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [2:0]                         paddr,
	input  logic [31:0]                        pwdata,
	input  logic                               pready,
	output int                                 fail_count,
	output int                                 pending
);

	localparam int PREEMPT_IDX = 0;

	typedef struct packed {
		logic [tts_pkg::RUN_W-1:0]   running;
		logic [tts_pkg::NEWID_W-1:0] new_id;
		tts_pkg::status_t            status;
	} sched_result_t;

	tts_pkg::slot_st_t          slot_tab[tts_pkg::THREADS];
	logic                       joiner_on[tts_pkg::THREADS];
	logic [tts_pkg::SLOT_W-1:0] joiner_of[tts_pkg::THREADS];
	logic [tts_pkg::SLOT_W-1:0] run_slot;
	logic                       preempt_on;
	sched_result_t              expected_results[$];

	// Hand the processor to the next active slot after the running one.
	function automatic tts_pkg::status_t ring_advance();
		int idx;
		tts_pkg::status_t sts;
		sts = tts_pkg::STS_NOOTHER;
		for (int k = 1; k < tts_pkg::THREADS; k++) begin
			idx = (int'(run_slot) + k) % tts_pkg::THREADS;
			if (sts == tts_pkg::STS_NOOTHER && slot_tab[idx] == tts_pkg::ST_ACTIVE) begin
				run_slot = tts_pkg::SLOT_W'(idx);
				sts = tts_pkg::STS_OK;
			end
		end
		return sts;
	endfunction

	function automatic sched_result_t schedule_step(input logic [tts_pkg::CMD_W-1:0] cmd,
			input logic [tts_pkg::TARGET_W-1:0] tgt);
		sched_result_t r;
		logic [tts_pkg::SLOT_W-1:0] cur;
		logic [tts_pkg::SLOT_W-1:0] wake;
		r.new_id = '0;
		r.status = tts_pkg::STS_OK;
		cur = run_slot;
		case (cmd)
			tts_pkg::CMD_CREATE: begin
				r.status = tts_pkg::STS_NOFREE;
				for (int i = 0; i < tts_pkg::THREADS; i++) begin
					if (r.status == tts_pkg::STS_NOFREE && slot_tab[i] == tts_pkg::ST_INVALID) begin
						slot_tab[i] = tts_pkg::ST_ACTIVE;
						joiner_on[i] = 1'b0;
						joiner_of[i] = '0;
						r.new_id = tts_pkg::NEWID_W'(i);
						r.status = tts_pkg::STS_OK;
					end
				end
			end
			tts_pkg::CMD_YIELD: begin
				r.status = ring_advance();
			end
			tts_pkg::CMD_EXIT: begin
				slot_tab[cur] = tts_pkg::ST_FINISHED;
				if (joiner_on[cur]) begin
					wake = joiner_of[cur];
					slot_tab[wake] = tts_pkg::ST_ACTIVE;
					slot_tab[cur] = tts_pkg::ST_INVALID;
					joiner_on[cur] = 1'b0;
					joiner_of[cur] = '0;
					run_slot = wake;
				end else begin
					r.status = ring_advance();
				end
			end
			tts_pkg::CMD_JOIN: begin
				if (tgt == cur || slot_tab[tgt] == tts_pkg::ST_INVALID) begin
					r.status = tts_pkg::STS_BADJOIN;
				end else if (slot_tab[tgt] == tts_pkg::ST_FINISHED) begin
					slot_tab[tgt] = tts_pkg::ST_INVALID;
					joiner_on[tgt] = 1'b0;
					joiner_of[tgt] = '0;
				end else begin
					// A previous joiner of the target is overwritten and stays blocked.
					slot_tab[cur] = tts_pkg::ST_BLOCKED;
					joiner_on[tgt] = 1'b1;
					joiner_of[tgt] = cur;
					slot_tab[tgt] = tts_pkg::ST_ACTIVE;
					run_slot = tgt;
				end
			end
			tts_pkg::CMD_TICK: begin
				if (preempt_on) begin
					r.status = ring_advance();
				end
			end
			default: begin
			end
		endcase
		r.running = run_slot;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		sched_result_t exp_r;
		sched_result_t got_r;
		if (!arst_n) begin
			for (int i = 0; i < tts_pkg::THREADS; i++) begin
				slot_tab[i] = (i == 0) ? tts_pkg::ST_ACTIVE : tts_pkg::ST_INVALID;
				joiner_on[i] = 1'b0;
				joiner_of[i] = '0;
			end
			run_slot = '0;
			preempt_on = 1'b0;
			expected_results.delete();
			fail_count = 0;
		end else begin
			if (psel && penable && pwrite && pready && (int'(paddr) >> 2) == PREEMPT_IDX) begin
				preempt_on = pwdata[0];
			end
			if (s_tvalid && s_tready) begin
				expected_results.push_back(schedule_step(s_tdata[2:0], s_tdata[9:3]));
			end
			if (m_tvalid && m_tready) begin
				got_r.running = m_tdata[6:0];
				got_r.new_id = m_tdata[13:7];
				got_r.status = tts_pkg::status_t'(m_tdata[15:14]);
				if (expected_results.size() == 0) begin
					$display("%0t: result beat with nothing expected: running %0d new_id %0d status %0d",
						$time, got_r.running, got_r.new_id, got_r.status);
					fail_count++;
				end else begin
					exp_r = expected_results.pop_front();
					if (got_r.running != exp_r.running) begin
						$display("%0t: running mismatch: expected %0d, actual %0d",
							$time, exp_r.running, got_r.running);
						fail_count++;
					end
					if (got_r.new_id != exp_r.new_id) begin
						$display("%0t: new_id mismatch: expected %0d, actual %0d",
							$time, exp_r.new_id, got_r.new_id);
						fail_count++;
					end
					if (got_r.status != exp_r.status) begin
						$display("%0t: status mismatch: expected %0d, actual %0d",
							$time, exp_r.status, got_r.status);
						fail_count++;
					end
				end
			end
		end
		pending = expected_results.size();
	end

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// Top of the thread table scheduler test: clock, reset, command and APB stimulus, verdict.
// Depends on tts_pkg, thread_table_scheduler and tts_scoreboard.
module testbench;

	localparam logic [2:0]                ADDR_PREEMPT   = 3'd0;
	localparam logic [2:0]                ADDR_SPARE     = 3'd4;
	localparam logic [tts_pkg::CMD_W-1:0] CMD_RSVD_FIRST = 3'd5;
	localparam logic [tts_pkg::CMD_W-1:0] CMD_RSVD_LAST  = 3'd7;
	localparam int                        CYCLE_LIMIT    = 2000000;
	localparam int                        TAIL_CYCLES    = 20;

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [tts_pkg::IN_W-1:0]   s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [tts_pkg::OUT_W-1:0]  m_tdata;
	logic                       psel;
	logic                       penable;
	logic                       pwrite;
	logic [2:0]                 paddr;
	logic [31:0]                pwdata;
	logic [31:0]                prdata;
	logic                       pready;
	int                         fail_count;
	int                         pending;
	int                         cycle_count;
	bit                         tx_quiet;
	bit                         rx_quiet;
	int                         rx_stall;
	int                         rx_hold;
	int                         results_taken;

	thread_table_scheduler u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	tts_scoreboard u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.pready     (pready),
		.fail_count (fail_count),
		.pending    (pending)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("testbench NOT OK");
			$finish;
		end
	end

	// Result side: short random stalls after each beat, and now and then a long hold-off
	// that backs the block up so that it stops taking commands.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_taken++;
			if (results_taken % 64 == 0) begin
				rx_quiet = ($urandom_range(0, 2) == 0);
			end
			if (results_taken == 40 || $urandom_range(0, 149) == 0) begin
				rx_hold = $urandom_range(200, 400);
			end else begin
				rx_stall = rx_quiet ? 0 : $urandom_range(0, 3);
			end
		end
		if (rx_hold > 0) begin
			rx_hold--;
			m_tready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	task automatic send_cmd(input logic [tts_pkg::CMD_W-1:0] cmd,
			input logic [tts_pkg::TARGET_W-1:0] tgt);
		int gap;
		gap = tx_quiet ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {{(tts_pkg::IN_W - tts_pkg::CMD_W - tts_pkg::TARGET_W){1'b0}}, tgt, cmd};
		do begin
			@(posedge clk);
		end while (!s_tready);
	endtask

	// Drop valid and wait until every predicted result beat has been taken.
	task automatic drain();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1'b1;
		pwrite <= 1'b1;
		penable <= 1'b0;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic random_cmds(input int count);
		int pick;
		logic [tts_pkg::CMD_W-1:0] cmd;
		logic [tts_pkg::TARGET_W-1:0] tgt;
		for (int n = 0; n < count; n++) begin
			if (n % 40 == 0) begin
				tx_quiet = ($urandom_range(0, 3) == 0);
			end
			pick = $urandom_range(0, 99);
			tgt = tts_pkg::TARGET_W'($urandom_range(0, 127));
			if (pick < 25) begin
				cmd = tts_pkg::CMD_CREATE;
			end else if (pick < 45) begin
				cmd = tts_pkg::CMD_YIELD;
			end else if (pick < 60) begin
				cmd = tts_pkg::CMD_EXIT;
			end else if (pick < 85) begin
				cmd = tts_pkg::CMD_JOIN;
				// Aim most joins at the low slots, where live threads usually sit.
				if ($urandom_range(0, 4) < 3) begin
					tgt = tts_pkg::TARGET_W'($urandom_range(0, 15));
				end
			end else if (pick < 95) begin
				cmd = tts_pkg::CMD_TICK;
			end else begin
				cmd = tts_pkg::CMD_W'($urandom_range(CMD_RSVD_FIRST, CMD_RSVD_LAST));
			end
			send_cmd(cmd, tgt);
		end
	endtask

	initial begin
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		arst_n <= 1'b0;
		tx_quiet = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		apb_write(ADDR_PREEMPT, 32'hFFFF_FFFE);
		// A write beyond the only register must leave preemption off.
		apb_write(ADDR_SPARE, 32'h0000_0001);

		// Directed walk through ticks, joins on every kind of slot, and exits.
		send_cmd(tts_pkg::CMD_TICK, 7'd0);
		send_cmd(tts_pkg::CMD_YIELD, 7'd0);
		send_cmd(tts_pkg::CMD_CREATE, 7'd127);
		send_cmd(tts_pkg::CMD_CREATE, 7'd0);
		send_cmd(tts_pkg::CMD_JOIN, 7'd1);
		send_cmd(tts_pkg::CMD_YIELD, 7'd0);
		send_cmd(tts_pkg::CMD_JOIN, 7'd0);
		send_cmd(tts_pkg::CMD_JOIN, 7'd1);
		send_cmd(tts_pkg::CMD_EXIT, 7'd0);
		send_cmd(tts_pkg::CMD_EXIT, 7'd0);
		send_cmd(tts_pkg::CMD_EXIT, 7'd0);
		send_cmd(tts_pkg::CMD_YIELD, 7'd0);
		send_cmd(tts_pkg::CMD_CREATE, 7'd0);
		send_cmd(tts_pkg::CMD_JOIN, 7'd2);
		send_cmd(tts_pkg::CMD_YIELD, 7'd0);
		send_cmd(tts_pkg::CMD_JOIN, 7'd2);
		send_cmd(tts_pkg::CMD_JOIN, 7'd0);
		send_cmd(tts_pkg::CMD_JOIN, 7'd127);
		send_cmd(CMD_RSVD_FIRST, 7'd0);
		send_cmd(CMD_RSVD_FIRST + 3'd1, 7'd85);
		send_cmd(CMD_RSVD_LAST, 7'd127);
		send_cmd(tts_pkg::CMD_CREATE, 7'd0);
		send_cmd(tts_pkg::CMD_EXIT, 7'd0);
		send_cmd(tts_pkg::CMD_YIELD, 7'd0);
		drain();

		apb_write(ADDR_PREEMPT, 32'h0000_0001);
		send_cmd(tts_pkg::CMD_TICK, 7'd42);
		random_cmds(110);
		drain();

		apb_write(ADDR_PREEMPT, 32'h8000_0000);
		random_cmds(90);
		drain();

		// Fill the table past its last slot, then keep going with a full table.
		apb_write(ADDR_PREEMPT, 32'hFFFF_FFFF);
		tx_quiet = 1'b0;
		for (int n = 0; n < tts_pkg::THREADS + 4; n++) begin
			send_cmd(tts_pkg::CMD_CREATE, tts_pkg::TARGET_W'($urandom_range(0, 127)));
		end
		random_cmds(90);
		drain();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && pending == 0) begin
			$display("testbench OK");
		end else begin
			$display("testbench NOT OK");
		end
		$finish;
	end

endmodule
